// File: hdl/lzd_pkg.sv
// Shared types and constants for the LZ77 token decoder.
// No dependencies; imported by every module of the decoder.
package lzd_pkg;

    localparam int DIST_W = 13;
    localparam int LEN_W  = 6;
    localparam int BYTE_W = 8;

    // Copy lengths above this are clipped.
    localparam logic [LEN_W-1:0] MAX_MATCH = LEN_W'(32);

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_COPY,
        SEQ_FOLLOW
    } seq_state_t;

    // One byte request handed from the sequencer to the datapath.
    typedef struct packed {
        logic              valid;     // request offered this cycle
        logic              from_mem;  // byte comes from the history ring
        logic              wr;        // append byte to history
        logic [BYTE_W-1:0] data;      // byte when not read from the ring
        logic              last;      // final result of the token
        logic              bad;       // rejected copy
    } issue_t;

endpackage

// File: hdl/lz77_token_decoder.sv
// Top level of the LZ77 token decoder: read stage, history write-back and
// output buffer. Depends on lzd_pkg, lzd_seq and lzd_history_ram.
//
// The decoder takes one token per request and returns one byte per result
// request. A token is accepted only when the previous token has issued all
// of its bytes; the accept cycle itself issues nothing, then the sequencer
// issues one byte per cycle while the output buffer has room (a literal's
// byte, or the clipped copy length plus the follow byte when nonzero), and
// the last byte then lands through the read stage. The issue rate is set
// by the single read port of the history ring, which serves one copied byte
// per cycle. Copied bytes are read in the cycle before their write-back;
// when a read hits the entry being written in that same cycle (overlapping
// copy at distance one), the byte is forwarded from the write path instead
// of the ring. A two-entry output buffer (output register plus skid) lets
// the consumer stall without losing bytes; issue pauses when the buffer
// would overflow. A copy token whose distance is zero or beyond the held
// history yields one result with bad_distance set and leaves history
// untouched. The ring needs no clearing pass: only written entries can ever
// be addressed.
module lz77_token_decoder
    import lzd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 4096
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_start_of_stream,
    input  logic [DIST_W-1:0] s_distance,
    input  logic [LEN_W-1:0]  s_match_length,
    input  logic [BYTE_W-1:0] s_next_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_out_byte,
    output logic              m_last_of_run,
    output logic              m_bad_distance
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);

    logic              accept;
    logic              seq_idle;
    issue_t            issue;
    logic [AW-1:0]     rd_addr;
    logic              issue_ok;
    logic              fire;
    logic [BYTE_W-1:0] ram_q;

    // History pointers.
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]     filled_reg, filled_next;

    // Read stage: one request in flight, resolved in the following cycle.
    logic              s1_valid_reg;
    logic              s1_from_mem_reg;
    logic              s1_wr_reg;
    logic [BYTE_W-1:0] s1_data_reg;
    logic              s1_last_reg;
    logic              s1_bad_reg;
    logic              s1_fwd_reg;
    logic [BYTE_W-1:0] s1_fwd_data_reg;
    logic [BYTE_W-1:0] land_byte;
    logic              land_wr;

    // Output register and skid entry.
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic              out_last_reg, out_last_next;
    logic              out_bad_reg, out_bad_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [BYTE_W-1:0] skid_byte_reg, skid_byte_next;
    logic              skid_last_reg, skid_last_next;
    logic              skid_bad_reg, skid_bad_next;
    logic              drain;
    logic [1:0]        occupancy;

    // Take a new token only when the sequencer is idle and nothing is in flight.
    assign s_ready = seq_idle && !s1_valid_reg;
    assign accept  = s_valid && s_ready;

    lzd_seq #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .AW           (AW),
        .CW           (CW)
    ) u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .start_of_stream (s_start_of_stream),
        .distance        (s_distance),
        .match_length    (s_match_length),
        .next_byte       (s_next_byte),
        .wr_ptr          (wr_ptr_reg),
        .filled          (filled_reg),
        .issue_ok        (issue_ok),
        .idle            (seq_idle),
        .issue           (issue),
        .rd_addr         (rd_addr)
    );

    // Issue only if the byte is sure to find room in the output buffer.
    assign drain     = out_valid_reg && m_ready;
    assign occupancy = 2'(out_valid_reg) + 2'(skid_valid_reg) + 2'(s1_valid_reg)
                       - 2'(drain);
    assign issue_ok  = (occupancy < 2'd2);
    assign fire      = issue.valid && issue_ok;

    // Resolve the byte in flight: forwarded, read from the ring, or carried.
    always_comb begin
        if (s1_from_mem_reg) begin
            land_byte = s1_fwd_reg ? s1_fwd_data_reg : ram_q;
        end else begin
            land_byte = s1_data_reg;
        end
        land_wr = s1_valid_reg && s1_wr_reg;
    end

    lzd_history_ram #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (land_wr),
        .wr_addr (wr_ptr_reg),
        .wr_data (land_byte),
        .rd_en   (fire && issue.from_mem),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // Advance write pointer and fill count on every appended byte; clear the
    // fill count when a token opens a new stream.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        filled_next = filled_reg;
        if (accept && s_start_of_stream) begin
            filled_next = '0;
        end
        if (land_wr) begin
            wr_ptr_next = (wr_ptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (filled_reg != CW'(WINDOW_DEPTH)) begin
                filled_next = filled_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            filled_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg   <= wr_ptr_next;
            filled_reg   <= filled_next;
            s1_valid_reg <= fire;
        end
    end

    // Capture the request; flag a read of the entry written in this cycle.
    always_ff @(posedge aclk) begin
        if (fire) begin
            s1_from_mem_reg <= issue.from_mem;
            s1_wr_reg       <= issue.wr;
            s1_data_reg     <= issue.data;
            s1_last_reg     <= issue.last;
            s1_bad_reg      <= issue.bad;
            s1_fwd_reg      <= land_wr && (rd_addr == wr_ptr_reg);
            s1_fwd_data_reg <= land_byte;
        end
    end

    // Output buffer: refill from skid first, park the landing byte in skid
    // when the output register is held.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_bad_next    = out_bad_reg;
        skid_valid_next = skid_valid_reg;
        skid_byte_next  = skid_byte_reg;
        skid_last_next  = skid_last_reg;
        skid_bad_next   = skid_bad_reg;
        priority if (skid_valid_reg) begin
            if (drain) begin
                out_valid_next  = 1'b1;
                out_byte_next   = skid_byte_reg;
                out_last_next   = skid_last_reg;
                out_bad_next    = skid_bad_reg;
                skid_valid_next = s1_valid_reg;
                skid_byte_next  = land_byte;
                skid_last_next  = s1_last_reg;
                skid_bad_next   = s1_bad_reg;
            end
        end else if (!out_valid_reg || drain) begin
            out_valid_next = s1_valid_reg;
            out_byte_next  = land_byte;
            out_last_next  = s1_last_reg;
            out_bad_next   = s1_bad_reg;
        end else begin
            skid_valid_next = s1_valid_reg;
            skid_byte_next  = land_byte;
            skid_last_next  = s1_last_reg;
            skid_bad_next   = s1_bad_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_bad_reg   <= out_bad_next;
        skid_byte_reg <= skid_byte_next;
        skid_last_reg <= skid_last_next;
        skid_bad_reg  <= skid_bad_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_out_byte     = out_byte_reg;
    assign m_last_of_run  = out_last_reg;
    assign m_bad_distance = out_bad_reg;

    // A byte never lands while the skid entry is still occupied.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(skid_valid_reg && s1_valid_reg))
        else $error("output buffer overflow");

    // The skid entry is only used behind a full output register.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry holds data with empty output register");

    // A rejected copy is always the final result of its token.
    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_bad_reg |-> out_last_reg)
        else $error("bad distance result not marked last");

    // The fill count saturates at the window depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CW'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

endmodule

// File: hdl/lzd_history_ram.sv
// History ring storage: one write port, one read port, registered read data.
// Depends on lzd_pkg for the byte width.
module lzd_history_ram
    import lzd_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] ring_mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/lzd_seq.sv
// Token sequencer: latches a token, checks its distance and steps out one
// byte request per cycle while issue_ok holds. Depends on lzd_pkg.
module lzd_seq
    import lzd_pkg::*;
#(
    parameter int WINDOW_DEPTH = 4096,
    parameter int AW           = 12,
    parameter int CW           = 13
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic              start_of_stream,
    input  logic [DIST_W-1:0] distance,
    input  logic [LEN_W-1:0]  match_length,
    input  logic [BYTE_W-1:0] next_byte,
    input  logic [AW-1:0]     wr_ptr,
    input  logic [CW-1:0]     filled,
    input  logic              issue_ok,
    output logic              idle,
    output issue_t            issue,
    output logic [AW-1:0]     rd_addr
);

    localparam int SW = ((CW > DIST_W) ? CW : DIST_W) + 1;

    seq_state_t        state_reg, state_next;
    logic [LEN_W-1:0]  len_left_reg, len_left_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [BYTE_W-1:0] tok_byte_reg, tok_byte_next;
    logic              tok_bad_reg, tok_bad_next;

    logic [SW-1:0]     dist_ext;
    logic [SW-1:0]     fill_eff;
    logic [SW-1:0]     src_sum;
    logic [AW-1:0]     src_ptr;
    logic              dist_bad;
    logic [LEN_W-1:0]  len_clip;
    logic              fire;

    always_comb begin
        dist_ext = SW'(distance);
        fill_eff = start_of_stream ? '0 : SW'(filled);
        dist_bad = (distance == '0) || (dist_ext > fill_eff);
        src_sum  = SW'(wr_ptr) + SW'(WINDOW_DEPTH) - dist_ext;
        if (src_sum >= SW'(WINDOW_DEPTH)) begin
            src_ptr = AW'(src_sum - SW'(WINDOW_DEPTH));
        end else begin
            src_ptr = AW'(src_sum);
        end
        len_clip = (match_length > MAX_MATCH) ? MAX_MATCH : match_length;
    end

    assign fire = issue.valid && issue_ok;

    // Next state and token registers.
    always_comb begin
        state_next    = state_reg;
        len_left_next = len_left_reg;
        rd_ptr_next   = rd_ptr_reg;
        tok_byte_next = tok_byte_reg;
        tok_bad_next  = tok_bad_reg;
        unique case (state_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    tok_byte_next = next_byte;
                    tok_bad_next  = 1'b0;
                    if (match_length == '0) begin
                        state_next = SEQ_FOLLOW;
                    end else if (dist_bad) begin
                        state_next    = SEQ_FOLLOW;
                        tok_byte_next = '0;
                        tok_bad_next  = 1'b1;
                    end else begin
                        state_next    = SEQ_COPY;
                        len_left_next = len_clip;
                        rd_ptr_next   = src_ptr;
                    end
                end
            end
            SEQ_COPY: begin
                if (fire) begin
                    len_left_next = len_left_reg - LEN_W'(1);
                    rd_ptr_next   = (rd_ptr_reg == AW'(WINDOW_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + AW'(1);
                    if (len_left_reg == LEN_W'(1)) begin
                        state_next = (tok_byte_reg != '0) ? SEQ_FOLLOW : SEQ_IDLE;
                    end
                end
            end
            SEQ_FOLLOW: begin
                if (fire) begin
                    state_next = SEQ_IDLE;
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    // Request offered to the datapath.
    always_comb begin
        issue   = '0;
        rd_addr = rd_ptr_reg;
        idle    = 1'b0;
        unique case (state_reg)
            SEQ_IDLE: begin
                idle = 1'b1;
            end
            SEQ_COPY: begin
                issue.valid    = 1'b1;
                issue.from_mem = 1'b1;
                issue.wr       = 1'b1;
                issue.last     = (len_left_reg == LEN_W'(1)) && (tok_byte_reg == '0);
            end
            SEQ_FOLLOW: begin
                issue.valid = 1'b1;
                issue.wr    = !tok_bad_reg;
                issue.data  = tok_byte_reg;
                issue.last  = 1'b1;
                issue.bad   = tok_bad_reg;
            end
            default: idle = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_left_reg <= len_left_next;
        rd_ptr_reg   <= rd_ptr_next;
        tok_byte_reg <= tok_byte_next;
        tok_bad_reg  <= tok_bad_next;
    end

endmodule

// File: verif/tb.sv
// Self-checking testbench for lz77_token_decoder: directed token table, then random
// token streams checked against a built-in history-ring predictor.
// Depends on lzd_pkg and the lz77_token_decoder RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lzd_pkg::*;

    localparam int WINDOW      = 4096;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int TAIL_CYCLES = 64;   // one worst-case token plus a full stall

    // One token as it goes onto the request channel.
    typedef struct packed {
        logic              sos;
        logic [DIST_W-1:0] reach;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] nb;
    } token_t;

    // One decoded byte as it comes off the result channel.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              bad;
    } byte_result_t;

    // Directed row: a token plus, where obvious, the single result it must give.
    typedef struct packed {
        logic              sos;
        logic [DIST_W-1:0] reach;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] nb;
        logic              typed;
        logic [BYTE_W-1:0] t_data;
        logic              t_last;
        logic              t_bad;
    } dir_row_t;

    // Shapes of the random token stream.
    typedef enum int {
        MIX_OPEN,   // short history, frequent restarts, many rejects
        MIX_FILL,   // long copies that fill the window and wrap the ring
        MIX_DEEP    // full window, distances reaching back to its far end
    } stim_mix_t;

    // Fill count after each row is noted where it matters for the next distances.
    localparam dir_row_t DIRECTED [21] = '{
        // copy straight after reset: nothing held yet
        '{1'b0, 13'd1,    6'd1,  8'h55, 1'b1, 8'h00, 1'b1, 1'b1},
        // zero distance
        '{1'b0, 13'd0,    6'd5,  8'h00, 1'b1, 8'h00, 1'b1, 1'b1},
        // literals: zero byte still emitted, distance ignored (fill 1, 2, 3)
        '{1'b0, 13'd8191, 6'd0,  8'h00, 1'b1, 8'h00, 1'b1, 1'b0},
        '{1'b0, 13'd0,    6'd0,  8'hFF, 1'b1, 8'hFF, 1'b1, 1'b0},
        '{1'b0, 13'd4096, 6'd0,  8'hA5, 1'b1, 8'hA5, 1'b1, 1'b0},
        // overlapping copy at distance one, no follow byte (fill 7)
        '{1'b0, 13'd1,    6'd4,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        // short copy with follow byte (fill 10)
        '{1'b0, 13'd3,    6'd2,  8'h3C, 1'b0, 8'h00, 1'b0, 1'b0},
        // distance field all ones, far too deep
        '{1'b0, 13'd8191, 6'd1,  8'h11, 1'b1, 8'h00, 1'b1, 1'b1},
        // full-window distance and length field all ones, history still short
        '{1'b0, 13'd4096, 6'd63, 8'h22, 1'b1, 8'h00, 1'b1, 1'b1},
        // one past the held history
        '{1'b0, 13'd11,   6'd1,  8'h01, 1'b1, 8'h00, 1'b1, 1'b1},
        // exactly the held history: reads the very first byte (fill 12)
        '{1'b0, 13'd10,   6'd1,  8'h01, 1'b0, 8'h00, 1'b0, 1'b0},
        // overlong match clipped to MAX_MATCH, follow byte FF (fill 45)
        '{1'b0, 13'd2,    6'd63, 8'hFF, 1'b0, 8'h00, 1'b0, 1'b0},
        // longest legal match from the oldest byte, no follow (fill 77)
        '{1'b0, 13'd45,   6'd32, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 13'd78,   6'd32, 8'h80, 1'b1, 8'h00, 1'b1, 1'b1},
        // just over MAX_MATCH (fill 110)
        '{1'b0, 13'd77,   6'd33, 8'h80, 1'b0, 8'h00, 1'b0, 1'b0},
        // restart on a copy: history count drops, so the copy is rejected
        '{1'b1, 13'd1,    6'd1,  8'h5A, 1'b1, 8'h00, 1'b1, 1'b1},
        // restart on a literal (fill 1)
        '{1'b1, 13'd0,    6'd0,  8'h7E, 1'b1, 8'h7E, 1'b1, 1'b0},
        // copies after restart; write pointer kept its place (fill 2, 4)
        '{1'b0, 13'd1,    6'd1,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, 13'd2,    6'd1,  8'h42, 1'b0, 8'h00, 1'b0, 1'b0},
        // older bytes exist in the ring but lie before the restart
        '{1'b0, 13'd5,    6'd3,  8'h42, 1'b1, 8'h00, 1'b1, 1'b1},
        '{1'b0, 13'd4,    6'd2,  8'h00, 1'b0, 8'h00, 1'b0, 1'b0}
    };

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic              s_start_of_stream;
    logic [DIST_W-1:0] s_distance;
    logic [LEN_W-1:0]  s_match_length;
    logic [BYTE_W-1:0] s_next_byte;
    logic              m_valid;
    logic              m_ready;
    logic [BYTE_W-1:0] m_out_byte;
    logic              m_last_of_run;
    logic              m_bad_distance;

    // Predictor state: our own copy of the history ring.
    logic [BYTE_W-1:0] hist_ring [WINDOW];
    int                hist_wp;
    int                hist_fill;

    byte_result_t      pending_bytes [$];   // bytes still owed by the decoder
    byte_result_t      token_bytes [$];     // bytes of the token just decoded

    // Typed-in expectation for the request currently on the channel.
    logic              drv_typed;
    byte_result_t      drv_expect;

    bit                send_calm;
    bit                take_calm;

    int                fail_count;
    int                cycle_count;
    int                tokens_taken;
    int                restarts_taken;
    int                bytes_seen;
    int                rejects_seen;
    int                ring_wraps;
    bit                window_full;

    lz77_token_decoder #(
        .WINDOW_DEPTH(WINDOW)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_start_of_stream (s_start_of_stream),
        .s_distance        (s_distance),
        .s_match_length    (s_match_length),
        .s_next_byte       (s_next_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_out_byte        (m_out_byte),
        .m_last_of_run     (m_last_of_run),
        .m_bad_distance    (m_bad_distance)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Append one byte to the predicted history, saturating the fill count.
    function automatic void append_history(input logic [BYTE_W-1:0] b);
        hist_ring[hist_wp] = b;
        hist_wp = (hist_wp + 1) % WINDOW;
        if (hist_wp == 0)
            ring_wraps++;
        if (hist_fill < WINDOW)
            hist_fill++;
        if (hist_fill == WINDOW)
            window_full = 1'b1;
    endfunction

    // Decode one token into token_bytes and advance the predicted history.
    task automatic decode_token(input token_t tok);
        int n;
        int src;
        logic [BYTE_W-1:0] b;
        token_bytes.delete();
        if (tok.sos)
            hist_fill = 0;
        if (tok.len == '0) begin
            append_history(tok.nb);
            token_bytes.insert(token_bytes.size(), '{tok.nb, 1'b1, 1'b0});
        end else if (tok.reach == '0 || int'(tok.reach) > hist_fill) begin
            // rejected copy: one flagged byte, history left alone
            token_bytes.insert(token_bytes.size(), '{8'h00, 1'b1, 1'b1});
        end else begin
            n = (tok.len > MAX_MATCH) ? int'(MAX_MATCH) : int'(tok.len);
            for (int i = 0; i < n; i++) begin
                // read from the live ring so overlapping copies repeat new bytes
                src = (hist_wp + WINDOW - int'(tok.reach)) % WINDOW;
                b = hist_ring[src];
                append_history(b);
                token_bytes.insert(token_bytes.size(),
                                   '{b, (i == n - 1) && (tok.nb == '0), 1'b0});
            end
            if (tok.nb != '0) begin
                append_history(tok.nb);
                token_bytes.insert(token_bytes.size(), '{tok.nb, 1'b1, 1'b0});
            end
        end
    endtask

    // Draw the next random token from the predicted history.
    function automatic token_t gen_token(input stim_mix_t mix);
        token_t t;
        int roll;
        int span;
        t.sos   = 1'b0;
        t.reach = DIST_W'($urandom);
        t.len   = '0;
        t.nb    = BYTE_W'($urandom);
        roll    = $urandom_range(0, 99);
        if (mix == MIX_OPEN && $urandom_range(0, 99) < 6)
            t.sos = 1'b1;
        else if (mix == MIX_DEEP && $urandom_range(0, 199) == 0)
            t.sos = 1'b1;

        if (hist_fill == 0 || (mix != MIX_FILL && roll < 30)) begin
            // literal; now and then a zero byte
            if ($urandom_range(0, 9) == 0)
                t.nb = '0;
        end else if (mix == MIX_FILL) begin
            t.reach = DIST_W'($urandom_range(1, hist_fill));
            t.len   = LEN_W'($urandom_range(32, 63));
            t.nb    = BYTE_W'($urandom_range(1, 255));
        end else if (roll < 40) begin
            // rejected copy: zero distance or beyond what is held
            t.len = LEN_W'($urandom_range(1, 63));
            if ($urandom_range(0, 3) == 0)
                t.reach = '0;
            else
                t.reach = DIST_W'($urandom_range(hist_fill + 1, 8191));
        end else begin
            span = (hist_fill < 4) ? hist_fill : 4;
            case ($urandom_range(0, 3))
                0: t.reach = DIST_W'($urandom_range(1, span));
                1: t.reach = DIST_W'(hist_fill - $urandom_range(0, span - 1));
                default: t.reach = DIST_W'($urandom_range(1, hist_fill));
            endcase
            roll = $urandom_range(0, 9);
            if (roll < 6)
                t.len = LEN_W'($urandom_range(1, 8));
            else if (roll < 9)
                t.len = LEN_W'($urandom_range(9, 32));
            else
                t.len = LEN_W'($urandom_range(33, 63));
            t.nb = ($urandom_range(0, 3) == 0) ? 8'h00 : BYTE_W'($urandom_range(1, 255));
        end
        return t;
    endfunction

    // Offer one request after a random gap and hold it until the decoder takes it.
    task automatic send_token(input token_t tok, input logic typed, input byte_result_t res);
        int gap;
        if ($urandom_range(0, 29) == 0)
            send_calm = !send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_start_of_stream <= tok.sos;
        s_distance        <= tok.reach;
        s_match_length    <= tok.len;
        s_next_byte       <= tok.nb;
        drv_typed         <= typed;
        drv_expect        <= res;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    // Scoreboard: check each result byte, then predict for each accepted request.
    always @(posedge aclk) begin : scoreboard
        byte_result_t got;
        byte_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = '{m_out_byte, m_last_of_run, m_bad_distance};
                bytes_seen++;
                if (got.bad)
                    rejects_seen++;
                if (pending_bytes.size() == 0) begin
                    $error("unexpected result byte %0h (last %0b, bad %0b)",
                           got.data, got.last, got.bad);
                    fail_count++;
                end else begin
                    want = pending_bytes.pop_front();
                    if (got.data !== want.data) begin
                        $error("out_byte: expected %0h, got %0h", want.data, got.data);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last_of_run: expected %0b, got %0b", want.last, got.last);
                        fail_count++;
                    end
                    if (got.bad !== want.bad) begin
                        $error("bad_distance: expected %0b, got %0b", want.bad, got.bad);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                // always advance the predictor; typed rows only swap the expectation
                decode_token('{s_start_of_stream, s_distance, s_match_length, s_next_byte});
                if (drv_typed)
                    pending_bytes.insert(pending_bytes.size(), drv_expect);
                else
                    foreach (token_bytes[i])
                        pending_bytes.insert(pending_bytes.size(), token_bytes[i]);
                tokens_taken++;
                if (s_start_of_stream)
                    restarts_taken++;
            end
        end
    end

    // Consumer: stall a random number of cycles before each result byte, or none in calm stretches.
    initial begin : consumer
        int pause;
        m_ready = 1'b0;
        do @(negedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 39) == 0)
                take_calm = !take_calm;
            pause = take_calm ? 0 : $urandom_range(0, 16);
            if (pause > 0) begin
                m_ready <= 1'b0;
                repeat (pause) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    // Watchdog: end a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still owed",
                     cycle_count, pending_bytes.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then three shapes of random stream.
    initial begin : stimulus
        token_t tok;
        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_start_of_stream = 1'b0;
        s_distance        = '0;
        s_match_length    = '0;
        s_next_byte       = '0;
        drv_typed         = 1'b0;
        drv_expect        = '0;
        hist_wp           = 0;
        hist_fill         = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Walk the directed table.
        foreach (DIRECTED[i]) begin
            tok = '{DIRECTED[i].sos, DIRECTED[i].reach, DIRECTED[i].len, DIRECTED[i].nb};
            send_token(tok, DIRECTED[i].typed,
                       '{DIRECTED[i].t_data, DIRECTED[i].t_last, DIRECTED[i].t_bad});
        end

        // Short histories with restarts and rejects mixed in.
        repeat (160) send_token(gen_token(MIX_OPEN), 1'b0, '0);
        // Long copies: fill the window and wrap the write pointer.
        repeat (140) send_token(gen_token(MIX_FILL), 1'b0, '0);
        // Full window: reach back as far as it allows.
        repeat (150) send_token(gen_token(MIX_DEEP), 1'b0, '0);

        // Drain: wait for every owed byte, then watch for strays.
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d tokens (%0d stream restarts), %0d result bytes, %0d rejects",
                 tokens_taken, restarts_taken, bytes_seen, rejects_seen);
        $display("History window reached full depth: %0b, ring wrapped %0d times",
                 window_full, ring_wraps);
        if (fail_count == 0 && pending_bytes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: files.f
hdl/lzd_pkg.sv
hdl/lzd_history_ram.sv
hdl/lzd_seq.sv
hdl/lz77_token_decoder.sv
verif/tb.sv
